// File: rtl/chebd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebd_pkg
// Shared constants, state codes and control bundle of the Chebyshev
// derivative series unit.
// ----------------------------------------------------------------------------
package chebd_pkg;

  localparam int MAX_TERMS = 64;
  localparam int ORDER_CAP = 4;

  localparam int LANES     = ORDER_CAP + 1;
  localparam int LANE_W    = $clog2(LANES);
  localparam int DEG_W     = $clog2(MAX_TERMS + 1);
  localparam int ORD_W     = 3;
  localparam int CNT_W     = 7;
  localparam int CMP_W     = (DEG_W > CNT_W) ? DEG_W : CNT_W;

  localparam int VAL_W     = 64;
  localparam int PT_W      = 32;
  localparam int FRAC_BITS = 22;
  localparam int PROD_SH   = 29;
  localparam int ACC_W     = VAL_W + PT_W;
  localparam int SCL_W     = ACC_W - PROD_SH;
  localparam int SUM_W     = 72;

  localparam logic signed [VAL_W-1:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [1:0] ST_OVF       = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_T1,
    S_LO,
    S_HI,
    S_SUM,
    S_WR
  } state_t;

  typedef struct packed {
    logic              start_err;
    logic              start_run;
    logic              set_t1;
    logic              mac_lo;
    logic              mac_hi;
    logic              sum_en;
    logic              wr_en;
    logic              emit;
    logic              done;
    logic [LANE_W-1:0] lane;
    logic [LANE_W-1:0] ord;
    logic [DEG_W-1:0]  deg;
  } ctrl_t;

endpackage

// File: rtl/chebd_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebd_mac
// Shared multiply-accumulate: forms lane * t over two 33x32 passes and
// returns the product scaled by 2^-29, rounded to nearest, ties away.
// ----------------------------------------------------------------------------
module chebd_mac
  import chebd_pkg::*;
(
  input  logic                    clk,
  input  ctrl_t                   ctrl,
  input  logic signed [VAL_W-1:0] lane_val,
  input  logic signed [PT_W-1:0]  point,
  output logic signed [SCL_W-1:0] scaled
);

  logic signed [PT_W:0]       mul_x;
  logic signed [VAL_W:0]      prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_sh;
  logic                       neg;

  // low pass takes the unsigned low word, high pass the signed high word
  assign mul_x    = ctrl.mac_lo ? {1'b0, lane_val[PT_W-1:0]}
                                : {lane_val[VAL_W-1], lane_val[VAL_W-1:PT_W]};
  assign prod     = mul_x * point;
  assign prod_ext = ACC_W'(prod);

  // bias of half an lsb, one less for a negative product so ties go away
  assign neg = (lane_val != '0) && (point != '0) && (lane_val[VAL_W-1] ^ point[PT_W-1]);
  assign rnd = (ACC_W'(1) <<< (PROD_SH - 1)) - ACC_W'({1'b0, neg});

  always_ff @(posedge clk) begin
    if (ctrl.mac_lo) begin
      acc <= prod_ext + rnd;
    end else if (ctrl.mac_hi) begin
      acc <= acc + (prod_ext <<< PT_W);
    end
  end

  assign acc_sh = acc >>> PROD_SH;
  assign scaled = acc_sh[SCL_W-1:0];

endmodule

// File: rtl/chebd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebd_seq
// Sequencer: walks the terms of a run and, for each term, the derivative
// lanes from the requested order down to zero through the shared MAC.
// ----------------------------------------------------------------------------
module chebd_seq
  import chebd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [ORD_W-1:0] in_order,
  input  logic [CNT_W-1:0] in_count,
  input  logic             slot_free,
  input  logic             ovf_any,
  output logic             ready,
  output ctrl_t            ctrl
);

  state_t           state;
  state_t           state_next;
  logic [ORD_W-1:0] ord;
  logic [DEG_W-1:0] wanted;
  logic [DEG_W-1:0] deg;
  logic [LANE_W-1:0] lane;
  logic             done;
  logic             bad;
  logic             cnt_zero;
  logic [DEG_W-1:0] cnt_clamp;
  logic             last_term;

  assign bad       = {1'b0, in_order} > (ORD_W + 1)'(ORDER_CAP);
  assign cnt_zero  = (in_count == '0);
  assign cnt_clamp = (CMP_W'(in_count) > CMP_W'(MAX_TERMS)) ? DEG_W'(MAX_TERMS)
                                                              : DEG_W'(in_count);
  assign last_term = ((DEG_W + 1)'(deg) + (DEG_W + 1)'(1)) == (DEG_W + 1)'(wanted);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (bad || !cnt_zero)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          if (done) begin
            state_next = S_IDLE;
          end else if (deg == '0) begin
            state_next = S_T1;
          end else begin
            state_next = S_LO;
          end
        end
      end
      S_T1:  state_next = S_EMIT;
      S_LO:  state_next = S_HI;
      S_HI:  state_next = S_SUM;
      S_SUM: state_next = S_WR;
      S_WR: begin
        state_next = (lane == '0) ? S_EMIT : S_LO;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl           = '0;
    ctrl.lane      = lane;
    ctrl.ord       = LANE_W'(ord);
    ctrl.deg       = deg;
    ctrl.done      = done;
    ready          = 1'b0;
    unique case (state)
      S_IDLE: begin
        ready          = 1'b1;
        ctrl.start_err = in_fire && bad;
        ctrl.start_run = in_fire && !bad && !cnt_zero;
      end
      S_EMIT:  ctrl.emit   = slot_free;
      S_T1:    ctrl.set_t1 = 1'b1;
      S_LO:    ctrl.mac_lo = 1'b1;
      S_HI:    ctrl.mac_hi = 1'b1;
      S_SUM:   ctrl.sum_en = 1'b1;
      S_WR:    ctrl.wr_en  = 1'b1;
      default: ctrl        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ord    <= '0;
      wanted <= '0;
      deg    <= '0;
      lane   <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_fire) begin
        ord    <= in_order;
        wanted <= cnt_clamp;
        deg    <= '0;
        done   <= bad || (cnt_clamp == DEG_W'(1));
      end
      if (state == S_EMIT && slot_free) begin
        deg  <= deg + DEG_W'(1);
        lane <= LANE_W'(ord);
      end
      if (state == S_T1) begin
        done <= (wanted == DEG_W'(2));
      end
      if (state == S_WR) begin
        if (lane == '0) begin
          done <= ovf_any || last_term;
        end else begin
          lane <= lane - LANE_W'(1);
        end
      end
    end
  end

  a_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LO || state == S_HI || state == S_SUM || state == S_WR)
      |-> (lane <= LANE_W'(ord)))
    else $error("lane beyond requested order");

  a_lane_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && lane != '0) |=> (state == S_LO && lane == $past(lane) - LANE_W'(1)))
    else $error("lane walk did not step down");

  a_t1_degree: assert property (@(posedge clk) disable iff (rst)
    (state == S_T1) |-> (deg == DEG_W'(1) && !done))
    else $error("first-degree setup out of sequence");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !done) |-> ((DEG_W + 1)'(deg) < (DEG_W + 1)'(wanted)))
    else $error("term emitted beyond requested count");

endmodule

// File: rtl/chebyshev_derivative_series_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_derivative_series_unit
// Emits the m-th derivative of Chebyshev T0..T(C-1) at a Q1.30 point as
// saturated Q41.22 values, one transaction per term, last term flagged.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  s_*      in   48     point[31:0] deriv_order[34:32] term_count[41:35]
//  m_*      out  72     basis_value[63:0] term_index[69:64] status[71:70], tlast
//
//  T0 needs only the emit step and T1 a setup step; each later term walks
//  lanes m down to 0, where each lane uses the shared 33x32 multiplier for two
//  passes, then one sum and one saturate/write step.
//  s_tready is high only while no run is active; a finished result may still
//  wait in the output register while the next transaction is taken.
//  A stalled m_tready holds the run at its next result. Reset is synchronous.
// ----------------------------------------------------------------------------
module chebyshev_derivative_series_unit
  import chebd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // point[31:0], deriv_order[34:32], term_count[41:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // basis_value[63:0], term_index[69:64], status[71:70]
  output logic        m_tlast    // last
);

  ctrl_t                   ctrl;
  logic                    in_fire;
  logic                    slot_free;
  logic                    ovf_any;
  logic                    ovf_now;
  logic                    ovf_acc;

  logic signed [PT_W-1:0]  in_point;
  logic [ORD_W-1:0]        in_order;
  logic [CNT_W-1:0]        in_count;

  logic signed [PT_W-1:0]  held_point;
  logic signed [VAL_W-1:0] prior [LANES];
  logic signed [VAL_W-1:0] older [LANES];

  logic signed [VAL_W-1:0] t_ext;
  logic signed [VAL_W-1:0] t_bias;
  logic signed [VAL_W-1:0] t_rnd;

  logic signed [SCL_W-1:0] scaled;
  logic [LANE_W-1:0]       lane_dn;
  logic signed [SUM_W-1:0] below_ext;
  logic signed [SUM_W-1:0] extra;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] clamped;

  logic signed [VAL_W-1:0] res_val;
  logic [1:0]              res_status;

  assign in_point  = s_tdata[31:0];
  assign in_order  = s_tdata[34:32];
  assign in_count  = s_tdata[41:35];
  assign in_fire   = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  chebd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_order  (in_order),
    .in_count  (in_count),
    .slot_free (slot_free),
    .ovf_any   (ovf_any),
    .ready     (s_tready),
    .ctrl      (ctrl)
  );

  chebd_mac u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .lane_val (prior[ctrl.lane]),
    .point    (held_point),
    .scaled   (scaled)
  );

  // T1 = t rescaled from Q1.30 to Q41.22, ties away from zero
  assign t_ext  = VAL_W'(held_point);
  assign t_bias = t_ext + 64'sd128 - VAL_W'({1'b0, held_point[PT_W-1]});
  assign t_rnd  = t_bias >>> 8;

  // 2k * lane(k-1) by shift-add over the bits of k
  assign lane_dn   = ctrl.lane - LANE_W'(1);
  assign below_ext = SUM_W'(prior[lane_dn]);
  always_comb begin
    extra = '0;
    for (int b = 0; b < LANE_W; b++) begin
      if (ctrl.lane[b]) begin
        extra = extra + (below_ext <<< (b + 1));
      end
    end
  end

  // saturate to 64 bits
  assign ovf_now = !((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]));
  assign clamped = ovf_now ? (sum[SUM_W-1] ? VAL_MIN : VAL_MAX) : sum[VAL_W-1:0];
  assign ovf_any = ovf_acc || ovf_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        prior[i] <= '0;
        older[i] <= '0;
      end
      ovf_acc <= 1'b0;
    end else begin
      if (ctrl.start_run) begin
        for (int i = 0; i < LANES; i++) begin
          prior[i] <= '0;
          older[i] <= (i == 0) ? ONE_Q : '0;
        end
      end
      if (ctrl.set_t1) begin
        prior[0] <= t_rnd;
        prior[1] <= ONE_Q;
      end
      // lanes run from high to low, so lane k-1 still holds the previous degree
      if (ctrl.wr_en) begin
        prior[ctrl.lane] <= clamped;
        older[ctrl.lane] <= prior[ctrl.lane];
        ovf_acc          <= ovf_any;
      end
      if (ctrl.emit) begin
        ovf_acc <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_point <= in_point;
    end
    if (ctrl.sum_en) begin
      sum <= SUM_W'(scaled) - SUM_W'(older[ctrl.lane])
             + ((ctrl.lane == '0) ? '0 : extra);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (ctrl.start_err) begin
      res_val    <= '0;
      res_status <= ST_BAD_ORDER;
    end
    if (ctrl.start_run) begin
      res_val    <= (in_order == '0) ? ONE_Q : '0;
      res_status <= ST_OK;
    end
    if (ctrl.set_t1) begin
      res_val <= (ctrl.ord == '0) ? t_rnd : ((ctrl.ord == LANE_W'(1)) ? ONE_Q : '0);
    end
    if (ctrl.wr_en) begin
      if (ctrl.lane == ctrl.ord) begin
        res_val <= clamped;
      end
      if (ctrl.lane == '0) begin
        res_status <= ovf_any ? ST_OVF : ST_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      m_tdata <= {res_status, 6'(ctrl.deg), res_val};
      m_tlast <= ctrl.done;
    end
  end

endmodule
